// File: hdl/irm_pkg.sv
// Shared types and constants for the I2C register master.
`timescale 1ns / 1ps
`default_nettype none
package irm_pkg;

   localparam int DEV_ADDR_W = 7;
   localparam int BYTE_W = 8;
   localparam int OPCODE_W = 2;
   localparam int BIT_CNT_W = 4;
   localparam int PHASE_W = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'h0E;
   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_TICK,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] reg_addr;
      logic [BYTE_W-1:0] write_data;
      logic              sda_in;
   } cmd_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_level;
      logic              sda_listening;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_byte;
      logic              rejected;
   } rsp_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE         = 6'd0,
      PH_START_PREP   = 6'd1,
      PH_START_SCL    = 6'd2,
      PH_START_SDA    = 6'd3,
      PH_DEVW_BIT     = 6'd4,
      PH_DEVW_LO      = 6'd5,
      PH_DEVW_ACK_SDA = 6'd6,
      PH_DEVW_ACK_HI  = 6'd7,
      PH_DEVW_ACK_LO  = 6'd8,
      PH_REG_BIT      = 6'd9,
      PH_REG_LO       = 6'd10,
      PH_REG_ACK_SDA  = 6'd11,
      PH_REG_ACK_HI   = 6'd12,
      PH_REG_ACK_LO   = 6'd13,
      PH_DAT_BIT      = 6'd14,
      PH_DAT_LO       = 6'd15,
      PH_NACK_SDA     = 6'd16,
      PH_NACK_HI      = 6'd17,
      PH_NACK_LO      = 6'd18,
      PH_STOP_LO      = 6'd19,
      PH_STOP_SDA     = 6'd20,
      PH_STOP_HI      = 6'd21,
      PH_STOP_REL     = 6'd22,
      PH_RS_PREP      = 6'd23,
      PH_RS_SCL       = 6'd24,
      PH_RS_SDA       = 6'd25,
      PH_DEVR_BIT     = 6'd26,
      PH_DEVR_LO      = 6'd27,
      PH_DEVR_ACK_SDA = 6'd28,
      PH_DEVR_ACK_HI  = 6'd29,
      PH_DEVR_ACK_LO  = 6'd30,
      PH_RD_PRE       = 6'd31,
      PH_RD_HI        = 6'd32,
      PH_RD_LO        = 6'd33
   } phase_type;

endpackage
`default_nettype wire

// File: hdl/irm_req_if.sv
// Request channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface irm_req_if;
   logic                            valid;
   logic                            ready;
   logic [irm_pkg::OPCODE_W-1:0]    opcode;
   logic [irm_pkg::BYTE_W-1:0]      reg_addr;
   logic [irm_pkg::BYTE_W-1:0]      write_data;
   logic                            sda_in;

   modport source (output valid, opcode, reg_addr, write_data, sda_in, input ready);
   modport sink (input valid, opcode, reg_addr, write_data, sda_in, output ready);
endinterface
`default_nettype wire

// File: hdl/irm_rsp_if.sv
// Response channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface irm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       scl_level;
   logic                       sda_level;
   logic                       sda_listening;
   logic                       busy_res;
   logic                       done_res;
   logic [irm_pkg::BYTE_W-1:0] read_byte;
   logic                       rejected;

   modport source (output valid, scl_level, sda_level, sda_listening, busy_res, done_res,
                   read_byte, rejected, input ready);
   modport sink (input valid, scl_level, sda_level, sda_listening, busy_res, done_res,
                 read_byte, rejected, output ready);
endinterface
`default_nettype wire

// File: hdl/i2c_register_master.sv
// Top level of the I2C register master.
`timescale 1ns / 1ps
`default_nettype none
// Bit-banged I2C master for register writes and reads. Every request beat
// (tick, write, read or spare) yields exactly one response beat carrying the
// SCL and SDA levels after that step, plus busy, done, rejected and the last
// byte read. One beat is taken per clock while the front or queue has room; it
// passes the front, queue and response registers. The sequencer advances one
// bus phase per tick beat. A two-entry request queue lets the request side keep
// going while the response side is stalled. The user must write the seven-bit
// device address (csr_wr_en, csr_wr_data; reset 0x0E) only while no beat is
// in flight; the block does not enforce it. Slave acknowledges are not checked.
module i2c_register_master (
   input  wire logic                           clock,
   input  wire logic                           reset,
   irm_req_if.sink                             req_bus,
   irm_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [irm_pkg::DEV_ADDR_W-1:0] csr_wr_data
);

   logic [irm_pkg::DEV_ADDR_W-1:0] dev_addr_ff;
   logic [irm_pkg::DEV_ADDR_W-1:0] dev_addr_in;
   logic                           queue_full;
   logic                           queue_empty;
   logic                           queue_push;
   logic                           queue_pop;
   irm_pkg::cmd_type               push_cmd;
   irm_pkg::cmd_type               head_cmd;
   irm_pkg::rsp_type               rsp;
   logic                           rsp_valid;

   assign dev_addr_in = csr_wr_en ? csr_wr_data : dev_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= irm_pkg::DEV_ADDR_RESET;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   irm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_opcode     (req_bus.opcode),
      .req_reg_addr   (req_bus.reg_addr),
      .req_write_data (req_bus.write_data),
      .req_sda_in     (req_bus.sda_in),
      .queue_full     (queue_full),
      .queue_push     (queue_push),
      .queue_cmd      (push_cmd)
   );

   irm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (push_cmd),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   irm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_empty (queue_empty),
      .cmd_pop   (queue_pop),
      .dev_addr  (dev_addr_ff),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_bus.valid = rsp_valid;
   assign rsp_bus.scl_level = rsp.scl_level;
   assign rsp_bus.sda_level = rsp.sda_level;
   assign rsp_bus.sda_listening = rsp.sda_listening;
   assign rsp_bus.busy_res = rsp.busy_res;
   assign rsp_bus.done_res = rsp.done_res;
   assign rsp_bus.read_byte = rsp.read_byte;
   assign rsp_bus.rejected = rsp.rejected;

endmodule
`default_nettype wire

// File: hdl/irm_front.sv
// Front stage: accept request beats and classify them into commands.
`timescale 1ns / 1ps
`default_nettype none
module irm_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [irm_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [irm_pkg::BYTE_W-1:0]   req_reg_addr,
   input  wire logic [irm_pkg::BYTE_W-1:0]   req_write_data,
   input  wire logic                         req_sda_in,
   input  wire logic                         queue_full,
   output logic                              queue_push,
   output irm_pkg::cmd_type                  queue_cmd
);

   logic             valid_ff;
   logic             valid_in;
   irm_pkg::cmd_type cmd_ff;
   irm_pkg::cmd_type cmd_in;
   logic             accept;

   assign queue_push = valid_ff && !queue_full;
   assign req_ready = !valid_ff || !queue_full;
   assign accept = req_valid && req_ready;
   assign queue_cmd = cmd_ff;

   always_comb begin
      cmd_in = cmd_ff;
      if (accept) begin
         cmd_in.reg_addr = req_reg_addr;
         cmd_in.write_data = req_write_data;
         cmd_in.sda_in = req_sda_in;
         case (irm_pkg::opcode_type'(req_opcode))
            irm_pkg::OP_TICK:  cmd_in.kind = irm_pkg::CMD_TICK;
            irm_pkg::OP_WRITE: cmd_in.kind = irm_pkg::CMD_WRITE;
            irm_pkg::OP_READ:  cmd_in.kind = irm_pkg::CMD_READ;
            default:           cmd_in.kind = irm_pkg::CMD_NOP;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (queue_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule
`default_nettype wire

// File: hdl/irm_queue.sv
// Short command queue between the front and the bus sequencer.
`timescale 1ns / 1ps
`default_nettype none
module irm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire irm_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output irm_pkg::cmd_type      head_cmd,
   output logic                  empty,
   output logic                  full
);

   irm_pkg::cmd_type                 slot_ff [irm_pkg::QUEUE_DEPTH];
   logic [irm_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [irm_pkg::QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [irm_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [irm_pkg::QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [irm_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [irm_pkg::QUEUE_CNT_W-1:0]  count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == irm_pkg::QUEUE_CNT_W'(irm_pkg::QUEUE_DEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];

   function automatic logic [irm_pkg::QUEUE_PTR_W-1:0] next_ptr(
      input logic [irm_pkg::QUEUE_PTR_W-1:0] ptr);
      if (ptr == irm_pkg::QUEUE_PTR_W'(irm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: hdl/irm_back.sv
// Bus sequencer: step the I2C phases per command and register the response.
`timescale 1ns / 1ps
`default_nettype none
module irm_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire irm_pkg::cmd_type               cmd,
   input  wire logic                           cmd_empty,
   output logic                                cmd_pop,
   input  wire logic [irm_pkg::DEV_ADDR_W-1:0] dev_addr,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output irm_pkg::rsp_type                    rsp
);

   irm_pkg::phase_type               phase_ff;
   irm_pkg::phase_type               phase_in;
   logic [irm_pkg::BIT_CNT_W-1:0]    bit_index_ff;
   logic [irm_pkg::BIT_CNT_W-1:0]    bit_index_in;
   logic [irm_pkg::BIT_CNT_W-1:0]    bit_inc;
   logic [irm_pkg::BYTE_W-1:0]       shifter_ff;
   logic [irm_pkg::BYTE_W-1:0]       shifter_in;
   logic [irm_pkg::BYTE_W-1:0]       shift_src;
   logic [irm_pkg::BYTE_W-1:0]       byte_src;
   logic                             is_read_ff;
   logic                             is_read_in;
   logic [irm_pkg::BYTE_W-1:0]       reg_ff;
   logic [irm_pkg::BYTE_W-1:0]       reg_in;
   logic [irm_pkg::BYTE_W-1:0]       data_ff;
   logic [irm_pkg::BYTE_W-1:0]       data_in;
   logic [irm_pkg::BYTE_W-1:0]       received_ff;
   logic [irm_pkg::BYTE_W-1:0]       received_in;
   logic                             scl_ff;
   logic                             scl_in;
   logic                             sda_ff;
   logic                             sda_in;
   logic                             done;
   logic                             rejected;
   logic                             is_request;
   logic                             start;
   logic                             advance;
   logic                             last_bit;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   irm_pkg::rsp_type                 rsp_ff;
   irm_pkg::rsp_type                 rsp_in;

   assign cmd_pop = !cmd_empty && (!rsp_valid_ff || rsp_ready);
   assign is_request = (cmd.kind == irm_pkg::CMD_WRITE) || (cmd.kind == irm_pkg::CMD_READ);
   assign start = cmd_pop && is_request && (phase_ff == irm_pkg::PH_IDLE);
   assign rejected = cmd_pop && is_request && (phase_ff != irm_pkg::PH_IDLE);
   assign advance = cmd_pop && (cmd.kind == irm_pkg::CMD_TICK)
                    && (phase_ff != irm_pkg::PH_IDLE);
   assign bit_inc = bit_index_ff + 1'b1;
   assign last_bit = bit_inc[irm_pkg::BIT_CNT_W-1];
   assign shift_src = (bit_index_ff == '0) ? byte_src : shifter_ff;

   always_comb begin
      case (phase_ff)
         irm_pkg::PH_DEVW_BIT: byte_src = {dev_addr, irm_pkg::RW_WRITE};
         irm_pkg::PH_REG_BIT:  byte_src = reg_ff;
         irm_pkg::PH_DAT_BIT:  byte_src = data_ff;
         default:              byte_src = {dev_addr, irm_pkg::RW_READ};
      endcase
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = irm_pkg::PH_START_PREP;
      end else if (advance) begin
         case (phase_ff)
            irm_pkg::PH_START_PREP:   phase_in = irm_pkg::PH_START_SCL;
            irm_pkg::PH_START_SCL:    phase_in = irm_pkg::PH_START_SDA;
            irm_pkg::PH_START_SDA:    phase_in = irm_pkg::PH_DEVW_BIT;
            irm_pkg::PH_DEVW_BIT:     phase_in = irm_pkg::PH_DEVW_LO;
            irm_pkg::PH_DEVW_LO: begin
               phase_in = last_bit ? irm_pkg::PH_DEVW_ACK_SDA : irm_pkg::PH_DEVW_BIT;
            end
            irm_pkg::PH_DEVW_ACK_SDA: phase_in = irm_pkg::PH_DEVW_ACK_HI;
            irm_pkg::PH_DEVW_ACK_HI:  phase_in = irm_pkg::PH_DEVW_ACK_LO;
            irm_pkg::PH_DEVW_ACK_LO:  phase_in = irm_pkg::PH_REG_BIT;
            irm_pkg::PH_REG_BIT:      phase_in = irm_pkg::PH_REG_LO;
            irm_pkg::PH_REG_LO: begin
               phase_in = last_bit ? irm_pkg::PH_REG_ACK_SDA : irm_pkg::PH_REG_BIT;
            end
            irm_pkg::PH_REG_ACK_SDA:  phase_in = irm_pkg::PH_REG_ACK_HI;
            irm_pkg::PH_REG_ACK_HI:   phase_in = irm_pkg::PH_REG_ACK_LO;
            irm_pkg::PH_REG_ACK_LO: begin
               phase_in = is_read_ff ? irm_pkg::PH_RS_PREP : irm_pkg::PH_DAT_BIT;
            end
            irm_pkg::PH_DAT_BIT:      phase_in = irm_pkg::PH_DAT_LO;
            irm_pkg::PH_DAT_LO: begin
               phase_in = last_bit ? irm_pkg::PH_NACK_SDA : irm_pkg::PH_DAT_BIT;
            end
            irm_pkg::PH_NACK_SDA:     phase_in = irm_pkg::PH_NACK_HI;
            irm_pkg::PH_NACK_HI:      phase_in = irm_pkg::PH_NACK_LO;
            irm_pkg::PH_NACK_LO:      phase_in = irm_pkg::PH_STOP_LO;
            irm_pkg::PH_STOP_LO:      phase_in = irm_pkg::PH_STOP_SDA;
            irm_pkg::PH_STOP_SDA:     phase_in = irm_pkg::PH_STOP_HI;
            irm_pkg::PH_STOP_HI:      phase_in = irm_pkg::PH_STOP_REL;
            irm_pkg::PH_STOP_REL:     phase_in = irm_pkg::PH_IDLE;
            irm_pkg::PH_RS_PREP:      phase_in = irm_pkg::PH_RS_SCL;
            irm_pkg::PH_RS_SCL:       phase_in = irm_pkg::PH_RS_SDA;
            irm_pkg::PH_RS_SDA:       phase_in = irm_pkg::PH_DEVR_BIT;
            irm_pkg::PH_DEVR_BIT:     phase_in = irm_pkg::PH_DEVR_LO;
            irm_pkg::PH_DEVR_LO: begin
               phase_in = last_bit ? irm_pkg::PH_DEVR_ACK_SDA : irm_pkg::PH_DEVR_BIT;
            end
            irm_pkg::PH_DEVR_ACK_SDA: phase_in = irm_pkg::PH_DEVR_ACK_HI;
            irm_pkg::PH_DEVR_ACK_HI:  phase_in = irm_pkg::PH_DEVR_ACK_LO;
            irm_pkg::PH_DEVR_ACK_LO:  phase_in = irm_pkg::PH_RD_PRE;
            irm_pkg::PH_RD_PRE:       phase_in = irm_pkg::PH_RD_HI;
            irm_pkg::PH_RD_HI:        phase_in = irm_pkg::PH_RD_LO;
            irm_pkg::PH_RD_LO: begin
               phase_in = last_bit ? irm_pkg::PH_NACK_SDA : irm_pkg::PH_RD_HI;
            end
            default:                  phase_in = irm_pkg::PH_IDLE;
         endcase
      end
   end

   // Line levels and datapath per phase
   always_comb begin
      bit_index_in = bit_index_ff;
      shifter_in = shifter_ff;
      is_read_in = is_read_ff;
      reg_in = reg_ff;
      data_in = data_ff;
      received_in = received_ff;
      scl_in = scl_ff;
      sda_in = sda_ff;
      done = 1'b0;
      if (start) begin
         reg_in = cmd.reg_addr;
         data_in = cmd.write_data;
         is_read_in = (cmd.kind == irm_pkg::CMD_READ);
         bit_index_in = '0;
      end else if (advance) begin
         case (phase_ff)
            irm_pkg::PH_START_PREP, irm_pkg::PH_RS_PREP: begin
               scl_in = 1'b0;
               sda_in = 1'b1;
            end
            irm_pkg::PH_START_SCL, irm_pkg::PH_RS_SCL, irm_pkg::PH_DEVW_ACK_HI,
            irm_pkg::PH_REG_ACK_HI, irm_pkg::PH_DEVR_ACK_HI, irm_pkg::PH_NACK_HI,
            irm_pkg::PH_STOP_HI: begin
               scl_in = 1'b1;
            end
            irm_pkg::PH_START_SDA, irm_pkg::PH_RS_SDA, irm_pkg::PH_DEVW_ACK_SDA,
            irm_pkg::PH_REG_ACK_SDA, irm_pkg::PH_DEVR_ACK_SDA, irm_pkg::PH_STOP_SDA: begin
               sda_in = 1'b0;
            end
            irm_pkg::PH_DEVW_BIT, irm_pkg::PH_REG_BIT, irm_pkg::PH_DAT_BIT,
            irm_pkg::PH_DEVR_BIT: begin
               sda_in = shift_src[irm_pkg::BYTE_W-1];
               scl_in = 1'b1;
               shifter_in = {shift_src[irm_pkg::BYTE_W-2:0], 1'b0};
            end
            irm_pkg::PH_DEVW_LO, irm_pkg::PH_REG_LO, irm_pkg::PH_DAT_LO,
            irm_pkg::PH_DEVR_LO: begin
               scl_in = 1'b0;
               bit_index_in = last_bit ? '0 : bit_inc;
            end
            irm_pkg::PH_DEVW_ACK_LO, irm_pkg::PH_REG_ACK_LO, irm_pkg::PH_DEVR_ACK_LO,
            irm_pkg::PH_NACK_LO, irm_pkg::PH_STOP_LO: begin
               scl_in = 1'b0;
            end
            irm_pkg::PH_RD_PRE: begin
               sda_in = 1'b1;
               shifter_in = '0;
               bit_index_in = '0;
            end
            irm_pkg::PH_RD_HI: begin
               scl_in = 1'b1;
               shifter_in = {shifter_ff[irm_pkg::BYTE_W-2:0], cmd.sda_in};
            end
            irm_pkg::PH_RD_LO: begin
               scl_in = 1'b0;
               bit_index_in = last_bit ? '0 : bit_inc;
               if (last_bit) begin
                  received_in = shifter_ff;
               end
            end
            irm_pkg::PH_NACK_SDA: begin
               sda_in = 1'b1;
            end
            irm_pkg::PH_STOP_REL: begin
               sda_in = 1'b1;
               done = 1'b1;
            end
            default: begin
               bit_index_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd_pop) begin
         rsp_in.scl_level = scl_in;
         rsp_in.sda_level = sda_in;
         rsp_in.sda_listening = (phase_in == irm_pkg::PH_RD_HI)
                                || (phase_in == irm_pkg::PH_RD_LO);
         rsp_in.busy_res = (phase_in != irm_pkg::PH_IDLE);
         rsp_in.done_res = done;
         rsp_in.read_byte = received_in;
         rsp_in.rejected = rejected;
      end
      rsp_valid_in = cmd_pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= irm_pkg::PH_IDLE;
         bit_index_ff <= '0;
         shifter_ff <= '0;
         is_read_ff <= 1'b0;
         reg_ff <= '0;
         data_ff <= '0;
         received_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bit_index_ff <= bit_index_in;
         shifter_ff <= shifter_in;
         is_read_ff <= is_read_in;
         reg_ff <= reg_in;
         data_ff <= data_in;
         received_ff <= received_in;
         scl_ff <= scl_in;
         sda_ff <= sda_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule
`default_nettype wire

// File: hdl/irm_checker.sv
// Port-level checks for the I2C register master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module irm_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       scl_level,
   input wire logic                       sda_level,
   input wire logic                       sda_listening,
   input wire logic                       busy_res,
   input wire logic                       done_res,
   input wire logic [irm_pkg::BYTE_W-1:0] read_byte,
   input wire logic                       rejected
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(busy_res) && $stable(done_res) && $stable(read_byte) && $stable(rejected))
      else $error("response beat changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_done_releases_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res && scl_level && sda_level && !rejected)
      else $error("stop completed without releasing the bus");

   a_listen_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sda_listening |-> busy_res && !done_res)
      else $error("SDA listening outside a read");

endmodule

bind i2c_register_master irm_checker u_irm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .scl_level     (rsp_bus.scl_level),
   .sda_level     (rsp_bus.sda_level),
   .sda_listening (rsp_bus.sda_listening),
   .busy_res      (rsp_bus.busy_res),
   .done_res      (rsp_bus.done_res),
   .read_byte     (rsp_bus.read_byte),
   .rejected      (rsp_bus.rejected)
);
`default_nettype wire

// File: tb/sv/irm_checker.sv
// Response predictor and checker for the I2C register master.
`timescale 1ns / 1ps
module irm_scoreboard (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [irm_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [irm_pkg::BYTE_W-1:0]     req_reg_addr,
   input  wire logic [irm_pkg::BYTE_W-1:0]     req_write_data,
   input  wire logic                           req_sda_in,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           rsp_scl_level,
   input  wire logic                           rsp_sda_level,
   input  wire logic                           rsp_sda_listening,
   input  wire logic                           rsp_busy_res,
   input  wire logic                           rsp_done_res,
   input  wire logic [irm_pkg::BYTE_W-1:0]     rsp_read_byte,
   input  wire logic                           rsp_rejected,
   input  wire logic                           csr_wr_en,
   input  wire logic [irm_pkg::DEV_ADDR_W-1:0] csr_wr_data,
   output int                                  pending,
   output int                                  errors
);

   logic [irm_pkg::DEV_ADDR_W-1:0] dev_addr;
   irm_pkg::phase_type             bus_phase;
   logic [irm_pkg::BIT_CNT_W-1:0]  bit_cnt;
   logic [irm_pkg::BYTE_W-1:0]     shift_reg;
   logic                           read_xfer;
   logic [irm_pkg::BYTE_W-1:0]     reg_latch;
   logic [irm_pkg::BYTE_W-1:0]     data_latch;
   logic [irm_pkg::BYTE_W-1:0]     rx_byte;
   logic                           scl_q;
   logic                           sda_q;
   irm_pkg::rsp_type               expected_beats[$];

   initial begin
      pending = 0;
      errors = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   function automatic logic [irm_pkg::BYTE_W-1:0] next_byte(input irm_pkg::phase_type ph);
      case (ph)
         irm_pkg::PH_DEVW_BIT: next_byte = {dev_addr, irm_pkg::RW_WRITE};
         irm_pkg::PH_REG_BIT:  next_byte = reg_latch;
         irm_pkg::PH_DAT_BIT:  next_byte = data_latch;
         default:              next_byte = {dev_addr, irm_pkg::RW_READ};
      endcase
   endfunction

   task automatic bus_step(input logic sample, output logic done);
      done = 1'b0;
      case (bus_phase)
         irm_pkg::PH_START_PREP, irm_pkg::PH_RS_PREP: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
         end
         irm_pkg::PH_START_SCL, irm_pkg::PH_RS_SCL: begin
            scl_q = 1'b1;
            bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
         end
         irm_pkg::PH_START_SDA, irm_pkg::PH_RS_SDA: begin
            sda_q = 1'b0;
            bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
         end
         irm_pkg::PH_DEVW_BIT, irm_pkg::PH_REG_BIT, irm_pkg::PH_DAT_BIT,
         irm_pkg::PH_DEVR_BIT: begin
            if (bit_cnt == '0)
               shift_reg = next_byte(bus_phase);
            sda_q = shift_reg[irm_pkg::BYTE_W-1];
            scl_q = 1'b1;
            shift_reg = shift_reg << 1;
            bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
         end
         irm_pkg::PH_DEVW_LO, irm_pkg::PH_REG_LO, irm_pkg::PH_DAT_LO,
         irm_pkg::PH_DEVR_LO: begin
            scl_q = 1'b0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= irm_pkg::BIT_CNT_W'(irm_pkg::BYTE_W)) begin
               bit_cnt = '0;
               bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
            end else begin
               bus_phase = irm_pkg::phase_type'(bus_phase - 6'd1);
            end
         end
         irm_pkg::PH_DEVW_ACK_SDA, irm_pkg::PH_REG_ACK_SDA, irm_pkg::PH_DEVR_ACK_SDA: begin
            sda_q = 1'b0;
            bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
         end
         irm_pkg::PH_DEVW_ACK_HI, irm_pkg::PH_REG_ACK_HI, irm_pkg::PH_DEVR_ACK_HI,
         irm_pkg::PH_NACK_HI: begin
            scl_q = 1'b1;
            bus_phase = irm_pkg::phase_type'(bus_phase + 6'd1);
         end
         irm_pkg::PH_DEVW_ACK_LO: begin
            scl_q = 1'b0;
            bus_phase = irm_pkg::PH_REG_BIT;
         end
         irm_pkg::PH_REG_ACK_LO: begin
            scl_q = 1'b0;
            bus_phase = read_xfer ? irm_pkg::PH_RS_PREP : irm_pkg::PH_DAT_BIT;
         end
         irm_pkg::PH_DEVR_ACK_LO: begin
            scl_q = 1'b0;
            bus_phase = irm_pkg::PH_RD_PRE;
         end
         irm_pkg::PH_RD_PRE: begin
            sda_q = 1'b1;
            shift_reg = '0;
            bit_cnt = '0;
            bus_phase = irm_pkg::PH_RD_HI;
         end
         irm_pkg::PH_RD_HI: begin
            scl_q = 1'b1;
            shift_reg = {shift_reg[irm_pkg::BYTE_W-2:0], sample};
            bus_phase = irm_pkg::PH_RD_LO;
         end
         irm_pkg::PH_RD_LO: begin
            scl_q = 1'b0;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= irm_pkg::BIT_CNT_W'(irm_pkg::BYTE_W)) begin
               bit_cnt = '0;
               rx_byte = shift_reg;
               bus_phase = irm_pkg::PH_NACK_SDA;
            end else begin
               bus_phase = irm_pkg::PH_RD_HI;
            end
         end
         irm_pkg::PH_NACK_SDA: begin
            sda_q = 1'b1;
            bus_phase = irm_pkg::PH_NACK_HI;
         end
         irm_pkg::PH_NACK_LO: begin
            scl_q = 1'b0;
            bus_phase = irm_pkg::PH_STOP_LO;
         end
         irm_pkg::PH_STOP_LO: begin
            scl_q = 1'b0;
            bus_phase = irm_pkg::PH_STOP_SDA;
         end
         irm_pkg::PH_STOP_SDA: begin
            sda_q = 1'b0;
            bus_phase = irm_pkg::PH_STOP_HI;
         end
         irm_pkg::PH_STOP_HI: begin
            scl_q = 1'b1;
            bus_phase = irm_pkg::PH_STOP_REL;
         end
         irm_pkg::PH_STOP_REL: begin
            sda_q = 1'b1;
            done = 1'b1;
            bus_phase = irm_pkg::PH_IDLE;
         end
         default: begin
            bus_phase = irm_pkg::PH_IDLE;
            bit_cnt = '0;
         end
      endcase
   endtask

   task automatic predict_beat(input logic [irm_pkg::OPCODE_W-1:0] op,
                               input logic [irm_pkg::BYTE_W-1:0] ra,
                               input logic [irm_pkg::BYTE_W-1:0] wd, input logic sample,
                               output irm_pkg::rsp_type want);
      logic done;
      logic rej;
      done = 1'b0;
      rej = 1'b0;
      if (op == irm_pkg::OP_WRITE || op == irm_pkg::OP_READ) begin
         if (bus_phase != irm_pkg::PH_IDLE) begin
            rej = 1'b1;
         end else begin
            reg_latch = ra;
            data_latch = wd;
            read_xfer = (op == irm_pkg::OP_READ);
            bit_cnt = '0;
            bus_phase = irm_pkg::PH_START_PREP;
         end
      end else if (op == irm_pkg::OP_TICK && bus_phase != irm_pkg::PH_IDLE) begin
         bus_step(sample, done);
      end
      want.scl_level = scl_q;
      want.sda_level = sda_q;
      want.sda_listening = (bus_phase == irm_pkg::PH_RD_HI || bus_phase == irm_pkg::PH_RD_LO);
      want.busy_res = (bus_phase != irm_pkg::PH_IDLE);
      want.done_res = done;
      want.read_byte = rx_byte;
      want.rejected = rej;
   endtask

   always @(posedge clock) begin
      irm_pkg::rsp_type want;
      if (reset) begin
         dev_addr = irm_pkg::DEV_ADDR_RESET;
         bus_phase = irm_pkg::PH_IDLE;
         bit_cnt = '0;
         shift_reg = '0;
         read_xfer = 1'b0;
         reg_latch = '0;
         data_latch = '0;
         rx_byte = '0;
         scl_q = 1'b1;
         sda_q = 1'b1;
         expected_beats.delete();
      end else begin
         if (csr_wr_en)
            dev_addr = csr_wr_data;
         if (req_valid && req_ready) begin
            predict_beat(req_opcode, req_reg_addr, req_write_data, req_sda_in, want);
            expected_beats.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("response beat with nothing predicted", 0, 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_scl_level !== want.scl_level)
                  report_mismatch("scl_level", rsp_scl_level, want.scl_level);
               if (rsp_sda_level !== want.sda_level)
                  report_mismatch("sda_level", rsp_sda_level, want.sda_level);
               if (rsp_sda_listening !== want.sda_listening)
                  report_mismatch("sda_listening", rsp_sda_listening, want.sda_listening);
               if (rsp_busy_res !== want.busy_res)
                  report_mismatch("busy_res", rsp_busy_res, want.busy_res);
               if (rsp_done_res !== want.done_res)
                  report_mismatch("done_res", rsp_done_res, want.done_res);
               if (rsp_read_byte !== want.read_byte)
                  report_mismatch("read_byte", rsp_read_byte, want.read_byte);
               if (rsp_rejected !== want.rejected)
                  report_mismatch("rejected", rsp_rejected, want.rejected);
            end
         end
      end
      pending <= expected_beats.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Stimulus, clock, reset and verdict for the I2C register master testbench.
`timescale 1ns / 1ps
module tb_top;

   localparam logic [irm_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;
   localparam int WRITE_TICKS = 64;
   localparam int READ_TICKS = 87;
   localparam int PHASE_BEATS = 60;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [irm_pkg::DEV_ADDR_W-1:0] csr_wr_data;
   int                             send_idle_pct;
   int                             recv_idle_pct;
   int                             beats_sent;
   int                             pending;
   int                             errors;
   logic                           bus_busy;

   irm_req_if req_bus ();
   irm_rsp_if rsp_bus ();

   i2c_register_master DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   irm_scoreboard scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_opcode        (req_bus.opcode),
      .req_reg_addr      (req_bus.reg_addr),
      .req_write_data    (req_bus.write_data),
      .req_sda_in        (req_bus.sda_in),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_scl_level     (rsp_bus.scl_level),
      .rsp_sda_level     (rsp_bus.sda_level),
      .rsp_sda_listening (rsp_bus.sda_listening),
      .rsp_busy_res      (rsp_bus.busy_res),
      .rsp_done_res      (rsp_bus.done_res),
      .rsp_read_byte     (rsp_bus.read_byte),
      .rsp_rejected      (rsp_bus.rejected),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .pending           (pending),
      .errors            (errors)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   // track the bus state from the last response beat
   always @(posedge clock) begin
      if (reset)
         bus_busy <= 1'b0;
      else if (rsp_bus.valid && rsp_bus.ready)
         bus_busy <= rsp_bus.busy_res;
   end

   task automatic send_beat(input logic [irm_pkg::OPCODE_W-1:0] op,
                            input logic [irm_pkg::BYTE_W-1:0] ra,
                            input logic [irm_pkg::BYTE_W-1:0] wd, input logic sda);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.reg_addr <= ra;
      req_bus.write_data <= wd;
      req_bus.sda_in <= sda;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_ticks(input int count, input int sda_mode);
      repeat (count) begin
         send_beat(irm_pkg::OP_TICK, irm_pkg::BYTE_W'($urandom), irm_pkg::BYTE_W'($urandom),
                   (sda_mode == 2) ? 1'($urandom_range(1)) : 1'(sda_mode));
      end
   endtask

   task automatic random_transfer();
      logic rd;
      int   n;
      rd = 1'($urandom_range(1));
      n = rd ? READ_TICKS : WRITE_TICKS;
      // cut some transfers short so the next request lands while busy
      if ($urandom_range(9) == 0)
         n = $urandom_range(1, n - 1);
      send_beat(rd ? irm_pkg::OP_READ : irm_pkg::OP_WRITE, irm_pkg::BYTE_W'($urandom),
                irm_pkg::BYTE_W'($urandom), 1'($urandom_range(1)));
      repeat (n) begin
         if ($urandom_range(39) == 0)
            send_beat(irm_pkg::OPCODE_W'($urandom_range(3)), irm_pkg::BYTE_W'($urandom),
                      irm_pkg::BYTE_W'($urandom), 1'($urandom_range(1)));
         send_ticks(1, 2);
      end
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic drain_bus();
      wait_quiet();
      while (bus_busy) begin
         send_ticks(1, 2);
         wait_quiet();
      end
   endtask

   task automatic write_dev_addr(input logic [irm_pkg::DEV_ADDR_W-1:0] value);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct);
      int start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
         if ($urandom_range(4) != 0)
            random_transfer();
         else
            repeat ($urandom_range(1, 5))
               send_beat(irm_pkg::OPCODE_W'($urandom_range(3)), irm_pkg::BYTE_W'($urandom),
                         irm_pkg::BYTE_W'($urandom), 1'($urandom_range(1)));
      end
      // drain so the bus is idle before the next address change
      drain_bus();
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = irm_pkg::OP_TICK;
      req_bus.reg_addr = '0;
      req_bus.write_data = '0;
      req_bus.sda_in = 1'b1;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 25;
      recv_idle_pct = 54;
      beats_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle bus: tick and spare opcode do nothing
      send_beat(irm_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1);
      send_beat(OP_SPARE, 8'h00, 8'h00, 1'b0);
      // write at reset address, then requests while busy
      send_beat(irm_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0);
      send_beat(irm_pkg::OP_READ, 8'h00, 8'hFF, 1'b1);
      send_beat(irm_pkg::OP_WRITE, 8'h5A, 8'hA5, 1'b0);
      send_beat(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
      send_ticks(WRITE_TICKS, 0);
      send_beat(irm_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b1);
      send_ticks(WRITE_TICKS, 1);
      // reads with the data line held high, then low
      send_beat(irm_pkg::OP_READ, 8'h00, 8'h00, 1'b1);
      send_ticks(READ_TICKS, 1);
      send_beat(irm_pkg::OP_READ, 8'hA5, 8'h3C, 1'b0);
      send_ticks(READ_TICKS, 0);
      send_ticks(4, 2);

      write_dev_addr(7'h7F);
      random_phase(25, 54);
      write_dev_addr(7'h00);
      random_phase(54, 25);
      write_dev_addr(irm_pkg::DEV_ADDR_W'($urandom));
      random_phase(0, 0);

      wait_quiet();
      repeat (10) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("i2c_register_master regression: pass");
      else
         $display("i2c_register_master regression: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("i2c_register_master regression: fail");
      $finish;
   end

endmodule
